// ----- src/clst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clst_pkg
// Shared types and constants of the cursor linked stack.
// ----------------------------------------------------------------------------
package clst_pkg;

    localparam int NODE_COUNT_DEF = 16;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_INS  = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] value;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_DROPPED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        M_PUSH,
        M_POP,
        M_INS,
        M_INS_POP
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE,
        S_LINK,
        S_POP,
        S_TOPV,
        S_DONE
    } t_state;

endpackage

// ----- src/clst_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clst_front
// Accepts input transactions, decodes the operation and queues the
// commands in a two-entry FIFO toward the execution side.
// ----------------------------------------------------------------------------
module clst_front
    import clst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_value,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready,
    output t_cmd       o_cmd
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       w_dec;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_dec.value = i_value;
        unique case (i_kind)
            2'd0:    w_dec.op = OP_PUSH;
            2'd1:    w_dec.op = OP_POP;
            2'd2:    w_dec.op = OP_INS;
            default: w_dec.op = OP_NOP;
        endcase
    end

    assign o_ready     = (r_count != 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_dec;
        end
    end

endmodule

// ----- src/clst_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clst_back
// Executes queued commands on the node store, the free list and the
// top and bottom cursors, and holds the result in an output register.
// ----------------------------------------------------------------------------
module clst_back
    import clst_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_top_value,
    output logic       o_is_empty,
    output logic       o_is_full,
    output t_status    o_status
);

    localparam int AW = $clog2(NODE_COUNT);
    localparam int IW = $clog2(NODE_COUNT + 1);
    localparam logic [IW-1:0] NONE = IW'(NODE_COUNT);

    logic [7:0]    r_value_mem [NODE_COUNT];
    logic [IW-1:0] r_next_mem  [NODE_COUNT];

    t_state        r_state,     n_state;
    t_mode         r_mode,      n_mode;
    t_status       r_status,    n_status;
    logic [7:0]    r_value,     n_value;
    logic [IW-1:0] r_node,      n_node;
    logic [IW-1:0] r_free,      n_free;
    logic [IW-1:0] r_top,       n_top;
    logic [IW-1:0] r_bottom,    n_bottom;
    logic [IW-1:0] r_fresh,     n_fresh;
    logic [7:0]    r_top_value, n_top_value;

    logic          r_out_valid;
    logic [7:0]    r_out_top;
    logic          r_out_empty;
    logic          r_out_full;
    t_status       r_out_status;

    logic [IW-1:0] r_next_rd;
    logic          r_rd_fresh;
    logic [IW-1:0] r_rd_impl;
    logic [7:0]    r_value_rd;

    logic          w_next_we;
    logic [IW-1:0] w_next_waddr;
    logic [IW-1:0] w_next_wdata;
    logic          w_value_we;
    logic [IW-1:0] w_value_waddr;
    logic [IW-1:0] w_next_raddr;
    logic [IW-1:0] w_value_raddr;
    logic [IW-1:0] w_rd_raw;
    logic [IW-1:0] w_rd_next;
    logic          w_out_free;
    logic          w_out_load;

    assign w_rd_raw   = r_rd_fresh ? r_rd_impl : r_next_rd;
    assign w_rd_next  = (w_rd_raw < NONE) ? w_rd_raw : NONE;
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_status      = r_status;
        n_value       = r_value;
        n_node        = r_node;
        n_free        = r_free;
        n_top         = r_top;
        n_bottom      = r_bottom;
        n_fresh       = r_fresh;
        n_top_value   = r_top_value;
        o_cmd_ready   = 1'b0;
        w_out_load    = 1'b0;
        w_next_we     = 1'b0;
        w_next_waddr  = r_free;
        w_next_wdata  = r_top;
        w_value_we    = 1'b0;
        w_value_waddr = r_free;
        w_next_raddr  = r_free;
        w_value_raddr = r_top;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_value  = i_cmd.value;
                    n_status = ST_DONE;
                    unique case (i_cmd.op)
                        OP_PUSH: begin
                            if (r_free == NONE) begin
                                n_status = ST_IGNORED;
                                n_state  = S_DONE;
                            end else begin
                                n_mode  = M_PUSH;
                                n_state = S_TAKE;
                            end
                        end
                        OP_POP: begin
                            if (r_top == NONE) begin
                                n_status = ST_IGNORED;
                                n_state  = S_DONE;
                            end else begin
                                n_mode       = M_POP;
                                w_next_raddr = r_top;
                                n_state      = S_POP;
                            end
                        end
                        OP_INS: begin
                            if (r_top == NONE || r_bottom == NONE) begin
                                n_mode  = M_PUSH;
                                n_state = (r_free == NONE) ? S_DONE : S_TAKE;
                            end else if (r_free == NONE) begin
                                n_mode       = M_INS_POP;
                                n_status     = ST_DROPPED;
                                w_next_raddr = r_top;
                                n_state      = S_POP;
                            end else begin
                                n_mode  = M_INS;
                                n_state = S_TAKE;
                            end
                        end
                        default: begin
                            n_status = ST_IGNORED;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_TAKE: begin
                n_free        = w_rd_next;
                if (r_free < r_fresh) begin
                    n_fresh = r_free;
                end
                w_value_we    = 1'b1;
                w_value_waddr = r_free;
                w_next_we     = 1'b1;
                w_next_waddr  = r_free;
                if (r_mode == M_PUSH) begin
                    w_next_wdata = r_top;
                    n_top        = r_free;
                    if (r_top == NONE) begin
                        n_bottom = r_free;
                    end
                    n_top_value  = r_value;
                    n_state      = S_DONE;
                end else begin
                    w_next_wdata = NONE;
                    n_node       = r_free;
                    n_state      = S_LINK;
                end
            end
            S_LINK: begin
                w_next_we    = 1'b1;
                w_next_waddr = r_bottom;
                w_next_wdata = r_node;
                n_bottom     = r_node;
                n_state      = S_DONE;
            end
            S_POP: begin
                w_next_we     = 1'b1;
                w_next_waddr  = r_top;
                w_next_wdata  = r_free;
                n_free        = r_top;
                n_top         = w_rd_next;
                if (w_rd_next == NONE) begin
                    n_bottom = NONE;
                end
                w_value_raddr = w_rd_next;
                n_state       = S_TOPV;
            end
            S_TOPV: begin
                n_top_value = (r_top == NONE) ? 8'd0 : r_value_rd;
                if (r_mode == M_INS_POP) begin
                    n_mode  = (r_top == NONE) ? M_PUSH : M_INS;
                    n_state = S_TAKE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= IW'(NODE_COUNT - 1);
            r_top       <= NONE;
            r_bottom    <= NONE;
            r_fresh     <= NONE;
            r_top_value <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_top       <= n_top;
            r_bottom    <= n_bottom;
            r_fresh     <= n_fresh;
            r_top_value <= n_top_value;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_status <= n_status;
        r_value  <= n_value;
        r_node   <= n_node;
        if (w_out_load) begin
            r_out_top    <= r_top_value;
            r_out_empty  <= (r_top == NONE);
            r_out_full   <= (r_free == NONE);
            r_out_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_next_we) begin
            r_next_mem[w_next_waddr[AW-1:0]] <= w_next_wdata;
        end
        if (w_value_we) begin
            r_value_mem[w_value_waddr[AW-1:0]] <= r_value;
        end
        r_next_rd  <= r_next_mem[w_next_raddr[AW-1:0]];
        r_rd_fresh <= (w_next_raddr < r_fresh);
        r_rd_impl  <= (w_next_raddr == '0) ? NONE : w_next_raddr - IW'(1);
        r_value_rd <= r_value_mem[w_value_raddr[AW-1:0]];
    end

    assign o_valid     = r_out_valid;
    assign o_top_value = r_out_top;
    assign o_is_empty  = r_out_empty;
    assign o_is_full   = r_out_full;
    assign o_status    = r_out_status;

endmodule

// ----- src/cursor_linked_stack_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_linked_stack_top
// Byte stack kept as a linked list in a node store with a free list.
// ----------------------------------------------------------------------------
// Each input transaction pushes a byte, pops the top, inserts a byte
// under the bottom element or, for the unused kind code, is ignored, and
// returns one result with the top byte, the empty and full flags and a
// status code. Commands wait in a two-entry queue while the execution
// side walks the node store, whose registered read port sets the pace.
// An insert into an empty stack runs as a push, and an insert into a
// full store pops the top first, then inserts. Node links need no
// clearing pass after reset: untouched nodes are tracked by a fill mark
// and their links are implied.
module cursor_linked_stack_top
    import clst_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_top_value,
    output logic       o_is_empty,
    output logic       o_is_full,
    output logic [1:0] o_status
);

    logic    w_cmd_valid;
    logic    w_cmd_ready;
    t_cmd    w_cmd;
    t_status w_status;

    clst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    clst_back #(
        .NODE_COUNT (NODE_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_top_value (o_top_value),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full),
        .o_status    (w_status)
    );

    assign o_status = w_status;

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_top_value == 8'd0)
        else $error("empty result carries nonzero top byte");

    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_empty && o_is_full))
        else $error("result reports empty and full together");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && w_status == ST_DROPPED |-> o_is_full && !o_is_empty)
        else $error("dropped top without a full store afterwards");

endmodule

// ----- tb/tb_cursor_linked_stack_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cursor_linked_stack_top
// Self-checking bench for the linked byte stack with its free list.
// ----------------------------------------------------------------------------
// Directed tests cover an ignored pop, an unused code and an insert on an
// empty stack, the byte extremes, a store filled up to the full mark, a push
// onto a full store and an insert under the bottom that drops the top.
// A random phase then runs biased segments that keep the stack swinging
// between empty and full. A local model of the node store predicts every
// result; each output transaction is compared field by field with the
// oldest prediction, while both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module tb_cursor_linked_stack_top;
    import clst_pkg::*;

    localparam int NODES = NODE_COUNT_DEF;
    localparam logic [4:0] NIL = 5'(NODES);
    localparam time RUN_LIMIT = 5ms;

    typedef struct {
        logic [7:0] top_value;
        logic       is_empty;
        logic       is_full;
        t_status    status;
    } t_stack_view;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_kind;
    logic [7:0] i_value;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_top_value;
    logic       o_is_empty;
    logic       o_is_full;
    logic [1:0] o_status;

    logic [7:0] node_byte [NODES];
    logic [4:0] node_link [NODES];
    logic [4:0] free_ptr;
    logic [4:0] top_ptr;
    logic [4:0] bottom_ptr;

    t_stack_view pending_views[$];
    int          mismatches = 0;
    bit          calm = 1'b0;
    int          sink_wait = 0;

    cursor_linked_stack_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_top_value (o_top_value),
        .o_is_empty  (o_is_empty),
        .o_is_full   (o_is_full),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_store();
        for (int i = 0; i < NODES; i++) begin
            node_byte[i] = 8'd0;
            node_link[i] = (i == 0) ? NIL : 5'(i - 1);
        end
        free_ptr   = NIL - 5'd1;
        top_ptr    = NIL;
        bottom_ptr = NIL;
    endfunction

    function automatic logic [4:0] grab_node();
        logic [4:0] n;
        n = free_ptr;
        if (n >= NIL) return NIL;
        free_ptr = (node_link[n] < NIL) ? node_link[n] : NIL;
        return n;
    endfunction

    function automatic void release_node(logic [4:0] n);
        if (n < NIL) begin
            node_link[n] = free_ptr;
            free_ptr     = n;
        end
    endfunction

    function automatic bit push_byte(logic [7:0] v);
        logic [4:0] n;
        n = grab_node();
        if (n >= NIL) return 1'b0;
        node_byte[n] = v;
        node_link[n] = top_ptr;
        if (top_ptr >= NIL) bottom_ptr = n;
        top_ptr = n;
        return 1'b1;
    endfunction

    function automatic bit pop_byte();
        logic [4:0] n;
        n = top_ptr;
        if (n >= NIL) return 1'b0;
        top_ptr = (node_link[n] < NIL) ? node_link[n] : NIL;
        if (top_ptr >= NIL) bottom_ptr = NIL;
        release_node(n);
        return 1'b1;
    endfunction

    function automatic t_status insert_under(logic [7:0] v);
        t_status    st;
        logic [4:0] n;
        st = ST_DONE;
        if (top_ptr >= NIL || bottom_ptr >= NIL) begin
            void'(push_byte(v));
            return ST_DONE;
        end
        if (free_ptr >= NIL) begin
            void'(pop_byte());
            st = ST_DROPPED;
            if (top_ptr >= NIL || bottom_ptr >= NIL) begin
                void'(push_byte(v));
                return st;
            end
        end
        n = grab_node();
        if (n >= NIL) return ST_IGNORED;
        node_byte[n]          = v;
        node_link[n]          = NIL;
        node_link[bottom_ptr] = n;
        bottom_ptr            = n;
        return st;
    endfunction

    function automatic void apply_command(t_op kind, logic [7:0] v);
        t_stack_view view;
        case (kind)
            OP_PUSH: view.status = push_byte(v) ? ST_DONE : ST_IGNORED;
            OP_POP:  view.status = pop_byte() ? ST_DONE : ST_IGNORED;
            OP_INS:  view.status = insert_under(v);
            default: view.status = ST_IGNORED;
        endcase
        view.top_value = (top_ptr < NIL) ? node_byte[top_ptr] : 8'd0;
        view.is_empty  = (top_ptr < NIL) ? 1'b0 : 1'b1;
        view.is_full   = (free_ptr < NIL) ? 1'b0 : 1'b1;
        pending_views.push_back(view);
    endfunction

    task automatic send_cmd(input t_op kind, input logic [7:0] v);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
        apply_command(kind, v);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge i_clk);
    endtask

    // sink side: hold ready low for a random number of cycles after each result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_ready) begin
                if (o_valid) begin
                    sink_wait = calm ? 0 : $urandom_range(0, 6);
                    if (sink_wait != 0) i_ready <= 1'b0;
                end
            end else if (sink_wait > 1) begin
                sink_wait--;
            end else begin
                sink_wait = 0;
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_stack_view exp_v;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_views.size() == 0) begin
                $display("%0t: unexpected result top=%0d empty=%0b full=%0b status=%0d",
                         $time, o_top_value, o_is_empty, o_is_full, o_status);
                mismatches++;
            end else begin
                exp_v = pending_views.pop_front();
                if (o_top_value !== exp_v.top_value) begin
                    $display("%0t: top_value expected %0d actual %0d",
                             $time, exp_v.top_value, o_top_value);
                    mismatches++;
                end
                if (o_is_empty !== exp_v.is_empty) begin
                    $display("%0t: is_empty expected %0b actual %0b",
                             $time, exp_v.is_empty, o_is_empty);
                    mismatches++;
                end
                if (o_is_full !== exp_v.is_full) begin
                    $display("%0t: is_full expected %0b actual %0b",
                             $time, exp_v.is_full, o_is_full);
                    mismatches++;
                end
                if (o_status !== exp_v.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_v.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_empty_stack();
        calm = 1'b1;
        send_cmd(OP_POP, 8'hA5);
        send_cmd(OP_NOP, 8'hFF);
        send_cmd(OP_INS, 8'h00);
        send_cmd(OP_POP, 8'h00);
        drain();
    endtask

    task automatic test_byte_extremes();
        calm = 1'b0;
        send_cmd(OP_PUSH, 8'hFF);
        send_cmd(OP_POP, 8'h00);
        drain();
    endtask

    task automatic test_full_store();
        calm = 1'b0;
        send_cmd(OP_PUSH, 8'h00);
        for (int i = 1; i < NODES - 2; i++) send_cmd(OP_PUSH, 8'(i * 17));
        send_cmd(OP_INS, 8'h5A);
        send_cmd(OP_PUSH, 8'hFF);
        send_cmd(OP_PUSH, 8'h3C);
        send_cmd(OP_PUSH, 8'h81);
        send_cmd(OP_INS, 8'hC3);
        drain();
    endtask

    task automatic test_random_traffic();
        int         bias;
        int         roll;
        logic [7:0] v;
        t_op        kind;
        for (int seg = 0; seg < 28; seg++) begin
            bias = $urandom_range(0, 3);
            calm = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < 40; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    kind = OP_NOP;
                end else begin
                    roll = $urandom_range(0, 99);
                    case (bias)
                        0:       kind = (roll < 70) ? OP_PUSH : (roll < 85) ? OP_INS : OP_POP;
                        1:       kind = (roll < 70) ? OP_POP : (roll < 85) ? OP_PUSH : OP_INS;
                        2:       kind = (roll < 55) ? OP_INS : (roll < 75) ? OP_PUSH : OP_POP;
                        default: kind = (roll < 35) ? OP_PUSH : (roll < 70) ? OP_POP : OP_INS;
                    endcase
                end
                roll = $urandom_range(0, 19);
                v = (roll == 0) ? 8'h00 : (roll == 1) ? 8'hFF : 8'($urandom_range(0, 255));
                send_cmd(kind, v);
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_kind  <= OP_PUSH;
        i_value <= 8'd0;
        i_ready <= 1'b1;
        clear_store();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_stack();
        test_byte_extremes();
        test_full_store();
        test_random_traffic();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_views.size() == 0) begin
            $display("cursor_linked_stack_top test passed");
        end else begin
            $display("cursor_linked_stack_top test failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT);
        $display("cursor_linked_stack_top test failed");
        $finish;
    end

endmodule
